// File: rtl/spaf_pkg.sv
`default_nettype none

package spaf_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int COEF_W         = 32;
  localparam int PROD_W         = SAMPLE_W + COEF_W;
  localparam int BASE_COUNT     = 31;
  localparam int BASE_FRAC_BITS = 22;
  localparam int TAPS_DEFAULT   = 31;
  localparam int FRAC_DEFAULT   = 22;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // base table in q1.22, rounded to nearest
  localparam int BASE_COEF [BASE_COUNT] = '{
    -3, 39, -203, 669, -1772, 4055, -8323, 15697,
    -27679, 46298, -74496, 117227, -184880, 306433, -609443, 3959492,
    890699, -369828, 209529, -128757, 80301, -49285, 29202, -16451,
    8677, -4210, 1833, -690, 209, -40, 3
  };

  // coefficient j rescaled to frac fractional bits, halves rounded away from zero
  function automatic logic signed [COEF_W-1:0] scaled_coef(input int j, input int frac);
    logic [COEF_W-1:0] mag;
    int c;
    if (j >= BASE_COUNT || j < 0) begin
      return '0;
    end
    c = BASE_COEF[j];
    mag = (c < 0) ? COEF_W'(-c) : COEF_W'(c);
    if (frac >= BASE_FRAC_BITS) begin
      mag = mag << (frac - BASE_FRAC_BITS);
    end else begin
      mag = (mag + (COEF_W'(1) << (BASE_FRAC_BITS - frac - 1))) >> (BASE_FRAC_BITS - frac);
    end
    return (c < 0) ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

`default_nettype wire

// File: rtl/spaf_in_if.sv
`default_nettype none

interface spaf_in_if import spaf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic                       frame_end;

  modport source (output valid, left_sample, right_sample, frame_end, input ready);
  modport sink (input valid, left_sample, right_sample, frame_end, output ready);
endinterface

`default_nettype wire

// File: rtl/spaf_out_if.sv
`default_nettype none

interface spaf_out_if import spaf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       frame_end_out;

  modport source (output valid, left_out, right_out, frame_end_out, input ready);
  modport sink (input valid, left_out, right_out, frame_end_out, output ready);
endinterface

`default_nettype wire

// File: rtl/spaf_delay.sv
`default_nettype none

module spaf_delay import spaf_pkg::*; #(
  parameter int TAPS = TAPS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic signed [SAMPLE_W-1:0] left,
  output logic signed [SAMPLE_W-1:0]      delayed
);

  localparam int DEPTH = (TAPS - 1) / 2;
  localparam int DW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           filled;
  logic [DW-1:0]              dp;
  logic signed [SAMPLE_W-1:0] rd_raw;
  logic                       rd_filled;

  always_ff @(posedge clk) begin
    if (step) begin
      rd_raw    <= mem[dp];
      rd_filled <= filled[dp];
      mem[dp]   <= left;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
      dp     <= '0;
    end else if (step) begin
      filled[dp] <= 1'b1;
      dp         <= (dp == DW'(DEPTH - 1)) ? '0 : dp + 1'b1;
    end
  end

  // never-written slots read as the zero the line starts with
  assign delayed = rd_filled ? rd_raw : '0;

endmodule

`default_nettype wire

// File: rtl/spaf_hist.sv
`default_nettype none

module spaf_hist import spaf_pkg::*; #(
  parameter int TAPS = TAPS_DEFAULT,
  localparam int HW  = $clog2(TAPS)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       we,
  input  wire logic [HW-1:0]              waddr,
  input  wire logic signed [SAMPLE_W-1:0] wdata,
  input  wire logic [HW-1:0]              raddr,
  output logic signed [SAMPLE_W-1:0]      rdata
);

  logic signed [SAMPLE_W-1:0] mem [TAPS];
  logic [TAPS-1:0]            filled;
  logic signed [SAMPLE_W-1:0] rd_raw;
  logic                       rd_filled;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_raw <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      rd_filled <= 1'b0;
    end else begin
      rd_filled <= filled[raddr];
      if (we) begin
        filled[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rd_filled ? rd_raw : '0;

endmodule

`default_nettype wire

// File: rtl/spaf_mac.sv
`default_nettype none

module spaf_mac import spaf_pkg::*; #(
  parameter int TAPS           = TAPS_DEFAULT,
  parameter int COEF_FRAC_BITS = FRAC_DEFAULT,
  localparam int HW            = $clog2(TAPS),
  localparam int ACC_W         = PROD_W + $clog2(TAPS)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       clear,
  input  wire logic                       issue,
  input  wire logic [HW-1:0]              tap,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic signed [ACC_W-1:0]         acc
);

  logic signed [COEF_W-1:0] coef_q;
  logic                     issue_q;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_v;

  // coefficient fetched alongside the history read so both line up
  always_ff @(posedge clk) begin
    coef_q <= scaled_coef(int'(tap), COEF_FRAC_BITS);
    prod   <= coef_q * sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_q <= 1'b0;
      prod_v  <= 1'b0;
      acc     <= '0;
    end else begin
      issue_q <= issue;
      prod_v  <= issue_q;
      if (clear) begin
        acc <= '0;
      end else if (prod_v) begin
        acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/stereo_phase_align_fir.sv
`default_nettype none

// channel   dir  payload                                  handshake
// stereo    in   left_sample, right_sample, frame_end     valid/ready
// aligned   out  left_out, right_out, frame_end_out       valid/ready
// cfg       in   cfg_wdata (correction_enable)            cfg_we, no wait
//
// with correction on, an item runs through these steps: take the beat and write
// the history, one tap a cycle through the single multiplier, drain the multiplier
// pipeline, round and saturate into the output register; pass-through goes from
// taking the beat straight to the output register.
// reset clears fill flags of both sample stores at once, no clearing sweep.
// a result waiting on aligned.ready does not block the next item's run, only
// its hand-over to the output register.

module stereo_phase_align_fir import spaf_pkg::*; #(
  parameter int TAPS           = TAPS_DEFAULT,
  parameter int COEF_FRAC_BITS = FRAC_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   cfg_we,
  input  wire logic   cfg_wdata,
  spaf_in_if.sink     stereo,
  spaf_out_if.source  aligned
);

  localparam int HW    = $clog2(TAPS);
  localparam int CW    = $clog2(TAPS + 2);
  localparam int ACC_W = PROD_W + $clog2(TAPS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic signed [ACC_W-1:0] FRAC_MASK = (ACC_W'(1) << COEF_FRAC_BITS) - 1'b1;
  localparam logic signed [ACC_W-1:0] ACC_MAX   = ACC_W'(SAMPLE_MAX);
  localparam logic signed [ACC_W-1:0] ACC_MIN   = {{(ACC_W - SAMPLE_W){1'b1}}, SAMPLE_MIN};

  logic                       enable;
  logic [1:0]                 state;
  logic                       bypass;
  logic [CW-1:0]              cnt;
  logic [HW-1:0]              hp;
  logic [HW-1:0]              rp;
  logic signed [SAMPLE_W-1:0] held_left;
  logic signed [SAMPLE_W-1:0] held_right;
  logic                       held_fe;

  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;
  logic                       out_fe;

  logic                       accept;
  logic                       issue;
  logic signed [SAMPLE_W-1:0] hist_rdata;
  logic signed [SAMPLE_W-1:0] delayed;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_bias;
  logic signed [ACC_W-1:0]    quo;
  logic signed [SAMPLE_W-1:0] right_sat;
  logic                       out_free;

  assign stereo.ready = (state == ST_IDLE);
  assign accept       = stereo.valid && stereo.ready;
  assign issue        = (state == ST_RUN) && (cnt < CW'(TAPS));
  assign out_free     = !out_valid || aligned.ready;

  spaf_delay #(.TAPS(TAPS)) u_delay (
    .clk     (clk),
    .rst     (rst),
    .step    (accept && enable),
    .left    (stereo.left_sample),
    .delayed (delayed)
  );

  spaf_hist #(.TAPS(TAPS)) u_hist (
    .clk   (clk),
    .rst   (rst),
    .we    (accept && enable),
    .waddr (hp),
    .wdata (stereo.right_sample),
    .raddr (rp),
    .rdata (hist_rdata)
  );

  spaf_mac #(.TAPS(TAPS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mac (
    .clk    (clk),
    .rst    (rst),
    .clear  (accept),
    .issue  (issue),
    .tap    (cnt[HW-1:0]),
    .sample (hist_rdata),
    .acc    (acc)
  );

  // truncate toward zero: bias negative sums before the arithmetic shift
  always_comb begin
    acc_bias = acc + (acc[ACC_W-1] ? FRAC_MASK : '0);
    quo      = acc_bias >>> COEF_FRAC_BITS;
    if (quo > ACC_MAX) begin
      right_sat = SAMPLE_MAX;
    end else if (quo < ACC_MIN) begin
      right_sat = SAMPLE_MIN;
    end else begin
      right_sat = quo[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_left  <= stereo.left_sample;
      held_right <= stereo.right_sample;
      held_fe    <= stereo.frame_end;
    end
    if (state == ST_DONE && out_free) begin
      out_left  <= bypass ? held_left : delayed;
      out_right <= bypass ? held_right : right_sat;
      out_fe    <= held_fe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable    <= 1'b1;
      state     <= ST_IDLE;
      bypass    <= 1'b0;
      cnt       <= '0;
      hp        <= '0;
      rp        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        enable <= cfg_wdata;
      end
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (aligned.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            bypass <= !enable;
            cnt    <= '0;
            rp     <= hp;
            if (enable) begin
              hp    <= (hp == HW'(TAPS - 1)) ? '0 : hp + 1'b1;
              state <= ST_RUN;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_RUN: begin
          cnt <= cnt + 1'b1;
          // walk back through the history, newest sample first
          if (issue) begin
            rp <= (rp == '0) ? HW'(TAPS - 1) : rp - 1'b1;
          end
          if (cnt == CW'(TAPS + 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign aligned.valid         = out_valid;
  assign aligned.left_out      = out_left;
  assign aligned.right_out     = out_right;
  assign aligned.frame_end_out = out_fe;

  a_run_after_accept: assert property (@(posedge clk) disable iff (rst)
    (accept && enable) |=> (state == ST_RUN))
    else $error("enabled beat did not start a filter run");

  a_bypass_path: assert property (@(posedge clk) disable iff (rst)
    (accept && !enable) |=> (state == ST_DONE && bypass))
    else $error("disabled beat did not go straight to hand-over");

  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    accept |=> (acc == '0))
    else $error("accumulator not cleared at start of item");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(aligned.valid) |-> $past(state == ST_DONE))
    else $error("result beat raised outside hand-over");

  a_hp_range: assert property (@(posedge clk) disable iff (rst)
    hp <= HW'(TAPS - 1))
    else $error("history pointer out of range");

endmodule

`default_nettype wire
